// ----- design/dls_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dls_pkg
// Shared codes, field widths and timing constants of the LOD selector.
// ----------------------------------------------------------------------------
package dls_pkg;

	localparam int COORD_W  = 24;
	localparam int VALUE_W  = 24;
	localparam int ADDR_W   = 9;
	localparam int STRIDE_W = 3;
	localparam int CHAIN_W  = ADDR_W - STRIDE_W;
	localparam int ACT_W    = 2;
	localparam int LOD_W    = 3;
	localparam int IN_W     = 256;
	localparam int OUT_W    = 8;
	localparam int CFG_AW   = 2;
	localparam int CFG_DW   = 16;

	localparam int DSQ_W = 50;
	localparam int SQ_W  = 54;
	localparam int CAP_W = 27;
	localparam logic [CAP_W-1:0] SQ_CAP = CAP_W'(1) << 26;

	localparam logic [ACT_W-1:0] ACT_WR_THR  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_WR_CNT  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_QUERY   = 2'd2;
	localparam logic [ACT_W-1:0] ACT_PREDICT = 2'd3;

	localparam logic [CFG_AW-1:0] CFG_BIAS  = 2'd0;
	localparam logic [CFG_AW-1:0] CFG_HYST  = 2'd1;
	localparam logic [CFG_AW-1:0] CFG_AHEAD = 2'd2;

	// Cycle at which the level walk issues its first read, and at which the
	// first compare happens.
	localparam int WALK0 = 8;
	localparam int CMP0  = 12;

endpackage

// ----- design/distance_lod_selector_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_lod_selector_top
// Level-of-detail selector with per-chain threshold and level count memories.
// A query beat's result comes from a preamble on one shared multiplier followed
// by a walk of the threshold memory, one level a cycle, over the chain's level
// count; no new beat is accepted until the query's result has been registered.
// Table writes do not start the query sequencer.
// Reset clears all level counts (valid bits) and loads the register defaults;
// thresholds are undefined until written.
// ----------------------------------------------------------------------------
module distance_lod_selector_top #(
	parameter int CHAIN_COUNT = 64,
	parameter int MAX_LEVELS  = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [dls_pkg::CFG_AW-1:0]    cfg_addr,
	input  logic [dls_pkg::CFG_DW-1:0]    cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// table_address, table_value, object_x/y/z, camera_x/y/z, velocity_x/y/z
	input  logic [dls_pkg::IN_W-1:0]      s_tdata,
	// action
	input  logic [dls_pkg::ACT_W-1:0]     s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// detail_level, cull_flag
	output logic [dls_pkg::OUT_W-1:0]     m_tdata
);

	localparam int CHAINS = (CHAIN_COUNT < 64) ? CHAIN_COUNT : 64;
	localparam int CW     = (CHAINS > 1) ? $clog2(CHAINS) : 1;
	localparam int CNT_W  = $clog2(MAX_LEVELS + 1);
	localparam int CYC_W  = $clog2(dls_pkg::CMP0 + MAX_LEVELS + 2);
	localparam int TA_W   = CW + dls_pkg::STRIDE_W;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_BUSY = 1'b1;

	typedef logic signed [dls_pkg::COORD_W-1:0] coord_t;

	logic                      state_q;
	logic [CYC_W-1:0]          cyc_q;
	logic [15:0]               bias_q;
	logic [7:0]                hyst_q;
	logic [15:0]               ahead_q;

	logic                      acc;
	logic [dls_pkg::CHAIN_W-1:0] in_chain;
	logic [dls_pkg::STRIDE_W-1:0] in_lvl;
	logic                      in_chain_ok;
	logic [CW-1:0]             in_idx;
	logic [dls_pkg::VALUE_W-1:0] in_value;

	logic [dls_pkg::ACT_W-1:0] act_q;
	logic                      chain_ok_q;
	logic [CW-1:0]             cidx_q;
	logic [dls_pkg::VALUE_W-1:0] val_q;
	coord_t ox_q, oy_q, oz_q, cx_q, cy_q, cz_q, vx_q, vy_q, vz_q;
	coord_t px_q, py_q, pz_q;

	logic [CNT_W-1:0]          cnt_mem [CHAINS];
	logic [CHAINS-1:0]         cnt_vld_q;
	logic [CNT_W-1:0]          cnt_rdata_q;
	logic                      cnt_hit_q;
	logic [CNT_W-1:0]          n_lv;

	logic [dls_pkg::VALUE_W-1:0] thr_mem [CHAINS * 8];
	logic [dls_pkg::VALUE_W-1:0] thr_rdata_q;
	logic                      thr_we;
	logic                      rd_en;
	logic [TA_W-1:0]           rd_addr;
	logic [CYC_W-1:0]          walk_lvl;

	logic signed [27:0]        mul_a, mul_b;
	logic signed [55:0]        prod_d, prod_q;
	logic signed [24:0]        dx, dy, dz, pdx, pdy, pdz;
	logic [dls_pkg::DSQ_W-1:0] dsq_q, pdsq_q;
	logic [dls_pkg::CAP_W-1:0] limc_q;
	logic [dls_pkg::SQ_W-1:0]  limsq_q;
	logic [31:0]               lim_raw;

	logic [39:0]               m1_s1;
	logic [40:0]               m2_s2;
	logic [dls_pkg::SQ_W-1:0]  sq_s3;
	logic [32:0]               s2_val;
	logic [dls_pkg::CAP_W-1:0] s2_cap;

	logic                      cmp_en;
	logic [CNT_W-1:0]          cmp_lvl;
	logic                      hit_c, hit_p;
	logic                      fnd_q, pfnd_q;
	logic [CNT_W-1:0]          lod_q, plod_q;

	logic [CYC_W-1:0]          fin_cyc;
	logic                      fin;
	logic [CNT_W-1:0]          lod_f, plod_f, lod_sel;
	logic                      m_tvalid_q;
	logic [dls_pkg::OUT_W-1:0] m_tdata_q;

	function automatic coord_t sat_pred(input coord_t cam, input logic signed [55:0] p);
		logic signed [33:0] sum;
		begin
			sum = 34'(cam) + $signed(p[41:8]);
			if (sum > 34'sd8388607) begin
				sat_pred = coord_t'(24'h7FFFFF);
			end else if (sum < -34'sd8388608) begin
				sat_pred = coord_t'(24'h800000);
			end else begin
				sat_pred = coord_t'(sum[23:0]);
			end
		end
	endfunction

	assign acc         = s_tvalid && s_tready;
	assign s_tready    = (state_q == ST_IDLE);
	assign in_chain    = s_tdata[dls_pkg::ADDR_W-1:dls_pkg::STRIDE_W];
	assign in_lvl      = s_tdata[dls_pkg::STRIDE_W-1:0];
	assign in_chain_ok = (32'(in_chain) < CHAIN_COUNT);
	assign in_idx      = CW'(in_chain);
	assign in_value    = s_tdata[32:9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q  <= 16'd256;
			hyst_q  <= 8'd0;
			ahead_q <= 16'd256;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				dls_pkg::CFG_BIAS:  bias_q  <= cfg_wdata;
				dls_pkg::CFG_HYST:  hyst_q  <= cfg_wdata[7:0];
				dls_pkg::CFG_AHEAD: ahead_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			act_q      <= s_tuser;
			chain_ok_q <= in_chain_ok;
			cidx_q     <= in_idx;
			val_q      <= in_value;
			ox_q <= s_tdata[56:33];
			oy_q <= s_tdata[80:57];
			oz_q <= s_tdata[104:81];
			cx_q <= s_tdata[128:105];
			cy_q <= s_tdata[152:129];
			cz_q <= s_tdata[176:153];
			vx_q <= s_tdata[200:177];
			vy_q <= s_tdata[224:201];
			vz_q <= s_tdata[248:225];
		end
	end

	// Level count memory with one valid bit per chain.
	always_ff @(posedge clk) begin
		if (acc && s_tuser == dls_pkg::ACT_WR_CNT && in_chain_ok) begin
			cnt_mem[in_idx] <= (in_value > 24'(MAX_LEVELS)) ? CNT_W'(MAX_LEVELS)
				: CNT_W'(in_value);
		end
		if (acc) begin
			cnt_rdata_q <= cnt_mem[in_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q <= '0;
			cnt_hit_q <= 1'b0;
		end else if (acc) begin
			cnt_hit_q <= cnt_vld_q[in_idx];
			if (s_tuser == dls_pkg::ACT_WR_CNT && in_chain_ok) begin
				cnt_vld_q[in_idx] <= 1'b1;
			end
		end
	end

	assign n_lv = (chain_ok_q && cnt_hit_q) ? cnt_rdata_q : '0;

	// Threshold memory.
	assign thr_we   = acc && s_tuser == dls_pkg::ACT_WR_THR && in_chain_ok
		&& (32'(in_lvl) < MAX_LEVELS);
	assign walk_lvl = cyc_q - CYC_W'(dls_pkg::WALK0);
	assign rd_en    = (state_q == ST_BUSY) && (cyc_q >= CYC_W'(dls_pkg::WALK0))
		&& (walk_lvl < CYC_W'(n_lv));
	assign rd_addr  = {cidx_q, walk_lvl[dls_pkg::STRIDE_W-1:0]};

	always_ff @(posedge clk) begin
		if (thr_we) begin
			thr_mem[{in_idx, in_lvl}] <= in_value;
		end
		if (rd_en) begin
			thr_rdata_q <= thr_mem[rd_addr];
		end
	end

	// Preamble: one product a cycle on a shared multiplier.
	assign dx  = 25'(ox_q) - 25'(cx_q);
	assign dy  = 25'(oy_q) - 25'(cy_q);
	assign dz  = 25'(oz_q) - 25'(cz_q);
	assign pdx = 25'(ox_q) - 25'(px_q);
	assign pdy = 25'(oy_q) - 25'(py_q);
	assign pdz = 25'(oz_q) - 25'(pz_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cyc_q)
			CYC_W'(0):  begin mul_a = 28'(dx);  mul_b = 28'(dx);  end
			CYC_W'(1):  begin mul_a = 28'(dy);  mul_b = 28'(dy);  end
			CYC_W'(2):  begin mul_a = 28'(dz);  mul_b = 28'(dz);  end
			CYC_W'(3):  begin mul_a = 28'(vx_q); mul_b = $signed({12'd0, ahead_q}); end
			CYC_W'(4):  begin mul_a = 28'(vy_q); mul_b = $signed({12'd0, ahead_q}); end
			CYC_W'(5):  begin mul_a = 28'(vz_q); mul_b = $signed({12'd0, ahead_q}); end
			CYC_W'(6):  begin
				mul_a = $signed({4'd0, val_q});
				mul_b = $signed({12'd0, bias_q});
			end
			CYC_W'(7):  begin mul_a = 28'(pdx); mul_b = 28'(pdx); end
			CYC_W'(8):  begin
				mul_a = $signed({1'b0, limc_q});
				mul_b = $signed({1'b0, limc_q});
			end
			CYC_W'(9):  begin mul_a = 28'(pdy); mul_b = 28'(pdy); end
			CYC_W'(10): begin mul_a = 28'(pdz); mul_b = 28'(pdz); end
			default: ;
		endcase
	end

	assign prod_d  = mul_a * mul_b;
	assign lim_raw = prod_q[39:8];

	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		if (state_q == ST_BUSY) begin
			case (cyc_q)
				CYC_W'(1):  dsq_q <= prod_q[dls_pkg::DSQ_W-1:0];
				CYC_W'(2),
				CYC_W'(3):  dsq_q <= dsq_q + prod_q[dls_pkg::DSQ_W-1:0];
				CYC_W'(4):  px_q <= sat_pred(cx_q, prod_q);
				CYC_W'(5):  py_q <= sat_pred(cy_q, prod_q);
				CYC_W'(6):  pz_q <= sat_pred(cz_q, prod_q);
				CYC_W'(7):  limc_q <= (lim_raw > 32'(dls_pkg::SQ_CAP)) ? dls_pkg::SQ_CAP
					: lim_raw[dls_pkg::CAP_W-1:0];
				CYC_W'(8):  pdsq_q <= prod_q[dls_pkg::DSQ_W-1:0];
				CYC_W'(9):  limsq_q <= prod_q[dls_pkg::SQ_W-1:0];
				CYC_W'(10),
				CYC_W'(11): pdsq_q <= pdsq_q + prod_q[dls_pkg::DSQ_W-1:0];
				default: ;
			endcase
		end
	end

	// Threshold scaling pipeline, one level a cycle.
	assign s2_val = m2_s2[40:8];
	assign s2_cap = (s2_val > 33'(dls_pkg::SQ_CAP)) ? dls_pkg::SQ_CAP
		: s2_val[dls_pkg::CAP_W-1:0];

	always_ff @(posedge clk) begin
		m1_s1 <= 40'(thr_rdata_q) * 40'(bias_q);
		if (cyc_q != CYC_W'(dls_pkg::WALK0 + 2)) begin
			m2_s2 <= 41'(m1_s1[39:8]) * 41'({1'b1, hyst_q});
		end else begin
			m2_s2 <= 41'({m1_s1[39:8], 8'd0});
		end
		sq_s3 <= dls_pkg::SQ_W'(s2_cap) * dls_pkg::SQ_W'(s2_cap);
	end

	assign cmp_lvl = CNT_W'(cyc_q - CYC_W'(dls_pkg::CMP0));
	assign cmp_en  = (state_q == ST_BUSY) && (cyc_q >= CYC_W'(dls_pkg::CMP0))
		&& (cyc_q < fin_cyc);
	assign hit_c   = {4'd0, dsq_q} <= sq_s3;
	assign hit_p   = {4'd0, pdsq_q} <= sq_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fnd_q  <= 1'b0;
			pfnd_q <= 1'b0;
		end else if (acc) begin
			fnd_q  <= 1'b0;
			pfnd_q <= 1'b0;
		end else if (cmp_en) begin
			if (!fnd_q && hit_c) begin
				fnd_q <= 1'b1;
			end
			if (!pfnd_q && hit_p) begin
				pfnd_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_en && !fnd_q && hit_c) begin
			lod_q <= cmp_lvl;
		end
		if (cmp_en && !pfnd_q && hit_p) begin
			plod_q <= cmp_lvl;
		end
	end

	assign fin_cyc = CYC_W'(dls_pkg::CMP0) + CYC_W'(n_lv);
	assign fin     = (state_q == ST_BUSY) && (cyc_q == fin_cyc)
		&& (!m_tvalid_q || m_tready);
	assign lod_f   = (n_lv == '0) ? '0 : (fnd_q ? lod_q : n_lv - CNT_W'(1));
	assign plod_f  = (n_lv == '0) ? '0 : (pfnd_q ? plod_q : n_lv - CNT_W'(1));
	assign lod_sel = (act_q == dls_pkg::ACT_PREDICT && plod_f < lod_f) ? plod_f : lod_f;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cyc_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc && (s_tuser == dls_pkg::ACT_QUERY
						|| s_tuser == dls_pkg::ACT_PREDICT)) begin
						state_q <= ST_BUSY;
						cyc_q   <= '0;
					end
				end
				ST_BUSY: begin
					if (fin) begin
						state_q <= ST_IDLE;
					end else if (cyc_q != fin_cyc) begin
						cyc_q <= cyc_q + CYC_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (fin) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			m_tdata_q <= {4'd0, {4'd0, dsq_q} > limsq_q, dls_pkg::LOD_W'(lod_sel)};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_busy_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BUSY |-> cyc_q <= fin_cyc)
		else $error("query sequencer ran past its final cycle");

	a_query_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == dls_pkg::ACT_QUERY
			|| s_tuser == dls_pkg::ACT_PREDICT)
		|=> state_q == ST_BUSY && cyc_q == '0)
		else $error("accepted query did not start the sequencer");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_BUSY))
		else $error("result beat appeared without a query in flight");

endmodule
